>>> src/bracket_quote_balance_checker_macros.svh
// Assertion macros shared by the bracket and quote balance checker.
`ifndef BRACKET_QUOTE_BALANCE_CHECKER_MACROS_SVH
`define BRACKET_QUOTE_BALANCE_CHECKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk_i and held off during reset.
`define BQBC_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bqbc assertion failed");

// Next-cycle implication, sampled on clk_i and held off during reset.
`define BQBC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bqbc assertion failed");

`else

`define BQBC_ASSERT_IMPLY(name, ante, cons)
`define BQBC_ASSERT_NEXT(name, ante, cons)

`endif

`endif

>>> src/bqbc_pkg.sv
// Types and constants shared by the bracket and quote balance checker modules.
package bqbc_pkg;

  // Codes kept on the opener stack.
  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_ROUND  = 3'd1,
    KIND_SQUARE = 3'd2,
    KIND_CURLY  = 3'd3,
    KIND_DQ     = 3'd4,
    KIND_SQ     = 3'd5
  } kind_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic exec;
    logic pop;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more_pops;
  } stat_t;

  // Characters of interest.
  localparam logic [7:0] CHAR_LPAREN  = 8'h28;
  localparam logic [7:0] CHAR_RPAREN  = 8'h29;
  localparam logic [7:0] CHAR_LSQUARE = 8'h5B;
  localparam logic [7:0] CHAR_RSQUARE = 8'h5D;
  localparam logic [7:0] CHAR_LCURLY  = 8'h7B;
  localparam logic [7:0] CHAR_RCURLY  = 8'h7D;
  localparam logic [7:0] CHAR_DQUOTE  = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE  = 8'h27;
  localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // Counter limits.
  localparam logic [15:0]        ERR_MAX = 16'hFFFF;
  localparam logic signed [15:0] BAL_MAX = 16'sh7FFF;
  localparam logic signed [15:0] BAL_MIN = 16'sh8000;

endpackage

>>> src/bqbc_ctrl.sv
// Controller state machine of the bracket and quote balance checker.
module bqbc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  bqbc_pkg::stat_t stat_i,
  output bqbc_pkg::cmd_t  cmd_o
);

  bqbc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bqbc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      bqbc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = bqbc_pkg::ST_EXEC;
        end
      end
      bqbc_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.more_pops ? bqbc_pkg::ST_POP : bqbc_pkg::ST_EMIT;
      end
      bqbc_pkg::ST_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = stat_i.more_pops ? bqbc_pkg::ST_POP : bqbc_pkg::ST_EMIT;
      end
      bqbc_pkg::ST_EMIT: begin
        // Once the output slot is free, the result leaves for the output register and the next byte may enter.
        if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          in_ready_o  = 1'b1;
          if (in_valid_i) begin
            cmd_o.accept = 1'b1;
            state_d      = bqbc_pkg::ST_EXEC;
          end else begin
            state_d = bqbc_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = bqbc_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> src/bqbc_dpath.sv
// Datapath of the bracket and quote balance checker: stack memory, counters and result register.
module bqbc_dpath #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          char_in_i,
  input  logic                restart_i,
  input  bqbc_pkg::cmd_t      cmd_i,
  output bqbc_pkg::stat_t     stat_o,
  output logic                all_fine_o,
  output logic [15:0]         paren_errors_o,
  output logic [15:0]         square_errors_o,
  output logic [15:0]         brace_errors_o,
  output logic                quote_error_o,
  output logic signed [15:0]  paren_balance_o,
  output logic signed [15:0]  square_balance_o,
  output logic signed [15:0]  brace_balance_o,
  output logic [6:0]          depth_now_o,
  output logic                overflowed_o
);

  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(STACK_DEPTH);

  // Opener stack, written at the top and read one entry below it.
  bqbc_pkg::kind_e mem_q [STACK_DEPTH];
  bqbc_pkg::kind_e rd_q;

  // Working state.
  logic [7:0]         char_q;
  logic [CntW-1:0]    top_q, top_d;
  logic               in_str_q, in_str_d;
  logic               in_chr_q, in_chr_d;
  logic               esc_q, esc_d;
  logic               qerr_q, qerr_d;
  logic               ovf_q, ovf_d;
  logic [15:0]        err_q [3];
  logic [15:0]        err_d [3];
  logic signed [15:0] bal_q [3];
  logic signed [15:0] bal_d [3];
  bqbc_pkg::kind_e    close_kind_q, close_kind_d;

  // Per-step controls.
  logic               push_en;
  bqbc_pkg::kind_e    push_kind;
  logic               bal_inc, bal_dec;
  bqbc_pkg::kind_e    bal_kind;
  logic               chk_en;
  bqbc_pkg::kind_e    chk_kind;
  logic               err_bump;
  bqbc_pkg::kind_e    err_kind;
  logic               more;
  logic               rd_en;
  logic [AddrW-1:0]   rd_addr;
  logic               lit;
  logic [7:0]         quote_char;
  bqbc_pkg::kind_e    quote_kind;
  logic               fine;

  assign lit        = in_str_q || in_chr_q;
  assign quote_char = in_str_q ? bqbc_pkg::CHAR_DQUOTE : bqbc_pkg::CHAR_SQUOTE;
  assign quote_kind = in_str_q ? bqbc_pkg::KIND_DQ : bqbc_pkg::KIND_SQ;

  // Byte decode, closer check and stack top update.
  always_comb begin
    top_d        = top_q;
    in_str_d     = in_str_q;
    in_chr_d     = in_chr_q;
    esc_d        = esc_q;
    qerr_d       = qerr_q;
    ovf_d        = ovf_q;
    close_kind_d = close_kind_q;
    push_en      = 1'b0;
    push_kind    = bqbc_pkg::KIND_NONE;
    bal_inc      = 1'b0;
    bal_dec      = 1'b0;
    bal_kind     = bqbc_pkg::KIND_NONE;
    chk_en       = 1'b0;
    chk_kind     = close_kind_q;
    err_bump     = 1'b0;
    err_kind     = bqbc_pkg::KIND_NONE;
    more         = 1'b0;

    if (cmd_i.exec) begin
      if (lit) begin
        // Inside a literal only escapes, the own quote and newline matter.
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (char_q == bqbc_pkg::CHAR_BSLASH) begin
          esc_d = 1'b1;
        end else if (char_q == quote_char || char_q == bqbc_pkg::CHAR_NEWLINE) begin
          if (char_q == bqbc_pkg::CHAR_NEWLINE) begin
            qerr_d = 1'b1;
          end
          if (top_q != '0 && rd_q == quote_kind) begin
            top_d = top_q - CntW'(1);
          end
          in_str_d = 1'b0;
          in_chr_d = 1'b0;
        end
      end else begin
        unique case (char_q)
          bqbc_pkg::CHAR_LPAREN: begin
            bal_inc = 1'b1; bal_kind = bqbc_pkg::KIND_ROUND;
            push_en = 1'b1; push_kind = bqbc_pkg::KIND_ROUND;
          end
          bqbc_pkg::CHAR_LSQUARE: begin
            bal_inc = 1'b1; bal_kind = bqbc_pkg::KIND_SQUARE;
            push_en = 1'b1; push_kind = bqbc_pkg::KIND_SQUARE;
          end
          bqbc_pkg::CHAR_LCURLY: begin
            bal_inc = 1'b1; bal_kind = bqbc_pkg::KIND_CURLY;
            push_en = 1'b1; push_kind = bqbc_pkg::KIND_CURLY;
          end
          bqbc_pkg::CHAR_RPAREN: begin
            bal_dec = 1'b1; bal_kind = bqbc_pkg::KIND_ROUND;
            chk_en  = 1'b1; chk_kind = bqbc_pkg::KIND_ROUND;
          end
          bqbc_pkg::CHAR_RSQUARE: begin
            bal_dec = 1'b1; bal_kind = bqbc_pkg::KIND_SQUARE;
            chk_en  = 1'b1; chk_kind = bqbc_pkg::KIND_SQUARE;
          end
          bqbc_pkg::CHAR_RCURLY: begin
            bal_dec = 1'b1; bal_kind = bqbc_pkg::KIND_CURLY;
            chk_en  = 1'b1; chk_kind = bqbc_pkg::KIND_CURLY;
          end
          bqbc_pkg::CHAR_DQUOTE: begin
            push_en = 1'b1; push_kind = bqbc_pkg::KIND_DQ;
            in_str_d = 1'b1;
          end
          bqbc_pkg::CHAR_SQUOTE: begin
            push_en = 1'b1; push_kind = bqbc_pkg::KIND_SQ;
            in_chr_d = 1'b1;
          end
          default: ;
        endcase
        close_kind_d = chk_kind;
      end
    end else if (cmd_i.pop) begin
      chk_en = 1'b1;
    end

    // One pop of a closer search: rd_q holds the entry just below the top.
    if (chk_en) begin
      if (top_q == '0) begin
        err_bump = 1'b1;
        err_kind = chk_kind;
      end else begin
        top_d = top_q - CntW'(1);
        if (rd_q != chk_kind) begin
          more = 1'b1;
          if (rd_q == bqbc_pkg::KIND_ROUND || rd_q == bqbc_pkg::KIND_SQUARE ||
              rd_q == bqbc_pkg::KIND_CURLY) begin
            err_bump = 1'b1;
            err_kind = rd_q;
          end else begin
            qerr_d = 1'b1;
          end
        end
      end
    end

    // Push, or flag the drop when the stack is full.
    if (push_en) begin
      if (top_q < DepthCnt) begin
        top_d = top_q + CntW'(1);
      end else begin
        push_en = 1'b0;
        ovf_d   = 1'b1;
      end
    end
  end

  // Saturating error counts and balances, one update per step at most.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      err_d[i] = err_q[i];
      bal_d[i] = bal_q[i];
      if (err_bump && err_kind == bqbc_pkg::kind_e'(3'(i + 1)) &&
          err_q[i] != bqbc_pkg::ERR_MAX) begin
        err_d[i] = err_q[i] + 16'd1;
      end
      if (bal_kind == bqbc_pkg::kind_e'(3'(i + 1))) begin
        if (bal_inc && bal_q[i] != bqbc_pkg::BAL_MAX) begin
          bal_d[i] = bal_q[i] + 16'sd1;
        end else if (bal_dec && bal_q[i] != bqbc_pkg::BAL_MIN) begin
          bal_d[i] = bal_q[i] - 16'sd1;
        end
      end
    end
  end

  // Read below the top at accept, and one further down while a search goes on.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AddrW'(top_q - CntW'(1));
    if (cmd_i.accept) begin
      rd_en = !restart_i && top_q != '0;
    end else if (more && top_q > CntW'(1)) begin
      rd_en   = 1'b1;
      rd_addr = AddrW'(top_q - CntW'(2));
    end
  end

  assign stat_o.more_pops = more;

  // Stack memory.
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem_q[AddrW'(top_q)] <= push_kind;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Byte and closer kind latched for the current item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      char_q <= char_in_i;
    end
    close_kind_q <= close_kind_d;
  end

  // Checker state; a restart clears it as the byte is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= '0;
      in_str_q <= 1'b0;
      in_chr_q <= 1'b0;
      esc_q    <= 1'b0;
      qerr_q   <= 1'b0;
      ovf_q    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        err_q[i] <= '0;
        bal_q[i] <= '0;
      end
    end else if (cmd_i.accept && restart_i) begin
      top_q    <= '0;
      in_str_q <= 1'b0;
      in_chr_q <= 1'b0;
      esc_q    <= 1'b0;
      qerr_q   <= 1'b0;
      ovf_q    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        err_q[i] <= '0;
        bal_q[i] <= '0;
      end
    end else begin
      top_q    <= top_d;
      in_str_q <= in_str_d;
      in_chr_q <= in_chr_d;
      esc_q    <= esc_d;
      qerr_q   <= qerr_d;
      ovf_q    <= ovf_d;
      for (int i = 0; i < 3; i++) begin
        err_q[i] <= err_d[i];
        bal_q[i] <= bal_d[i];
      end
    end
  end

  assign fine = top_q == '0 && err_q[0] == '0 && err_q[1] == '0 && err_q[2] == '0 &&
                !qerr_q && !ovf_q;

  // Result register, loaded when the finished item is handed over.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      all_fine_o       <= fine;
      paren_errors_o   <= err_q[0];
      square_errors_o  <= err_q[1];
      brace_errors_o   <= err_q[2];
      quote_error_o    <= qerr_q;
      paren_balance_o  <= bal_q[0];
      square_balance_o <= bal_q[1];
      brace_balance_o  <= bal_q[2];
      depth_now_o      <= 7'(top_q);
      overflowed_o     <= ovf_q;
    end
  end

endmodule

>>> src/bracket_quote_balance_checker.sv
// Top level of the bracket and quote balance checker.
//
// Source text enters one byte per transfer on the input channel (char_in_i,
// restart_i, in_valid_i/in_ready_o). Each byte yields exactly one result
// transfer on the output channel (out_valid_o/out_ready_i) with balances,
// saturating error counts, sticky flags, stack depth and an all-fine flag.
// Setting restart_i clears all checker state before that byte is handled.
// A byte passes from accept through an execute step, a pop step for each
// opener of another kind that a closer pops off the stack, and an emit step
// into the output register: the closer search reads one stack memory entry
// per cycle. A new byte is accepted only once the last one reaches its emit step.
// A finished result waits in the output register while the next byte is
// already accepted and worked on; a stalled receiver holds the block only
// when the next result is ready to replace it.
// After reset the stack is empty, all counts are zero and no result is
// pending; no clearing pass is needed.
`include "bracket_quote_balance_checker_macros.svh"

module bracket_quote_balance_checker #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         char_in_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               all_fine_o,
  output logic [15:0]        paren_errors_o,
  output logic [15:0]        square_errors_o,
  output logic [15:0]        brace_errors_o,
  output logic               quote_error_o,
  output logic signed [15:0] paren_balance_o,
  output logic signed [15:0] square_balance_o,
  output logic signed [15:0] brace_balance_o,
  output logic [6:0]         depth_now_o,
  output logic               overflowed_o
);

  bqbc_pkg::cmd_t  cmd;
  bqbc_pkg::stat_t stat;

  // Sequencing of accept, pop steps and result transfer.
  bqbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Stack, counters and result register.
  bqbc_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .char_in_i        (char_in_i),
    .restart_i        (restart_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .all_fine_o       (all_fine_o),
    .paren_errors_o   (paren_errors_o),
    .square_errors_o  (square_errors_o),
    .brace_errors_o   (brace_errors_o),
    .quote_error_o    (quote_error_o),
    .paren_balance_o  (paren_balance_o),
    .square_balance_o (square_balance_o),
    .brace_balance_o  (brace_balance_o),
    .depth_now_o      (depth_now_o),
    .overflowed_o     (overflowed_o)
  );

  // An accepted byte is always worked on before the next one enters.
  `BQBC_ASSERT_NEXT(a_accept_then_busy, in_valid_i && in_ready_o, !in_ready_o)
  // A result handed over shows up as valid in the next cycle.
  `BQBC_ASSERT_NEXT(a_emit_then_valid, cmd.emit, out_valid_o)
  // The search only continues during an execute or pop step.
  `BQBC_ASSERT_IMPLY(a_more_in_step, stat.more_pops, cmd.exec || cmd.pop)
  // All fine means no errors, no flags and an empty stack.
  `BQBC_ASSERT_IMPLY(a_fine_consistent, out_valid_o && all_fine_o,
    paren_errors_o == 16'd0 && square_errors_o == 16'd0 && brace_errors_o == 16'd0 &&
    !quote_error_o && !overflowed_o && depth_now_o == 7'd0)

endmodule
